// File: hdl/balance_board_sample_conditioner_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sample conditioner RTL.
// ----------------------------------------------------------------------------
`ifndef BALANCE_BOARD_SAMPLE_CONDITIONER_MACROS_SVH
`define BALANCE_BOARD_SAMPLE_CONDITIONER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define BBSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is active
`define BBSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bbsc_pkg.sv
// ----------------------------------------------------------------------------
// bbsc_pkg
// Types and constants shared by the balance board sample conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsc_pkg;

  localparam int ValueBits  = 16;
  localparam int BoardCount = 8;
  localparam int BoardW     = 3;
  localparam int OpW        = 2;
  localparam int CfgIdxW    = 2;
  localparam int NormW      = 18;
  localparam int QuotBits   = 18;
  localparam int FracShift  = 12;
  localparam int AccW       = 2 * ValueBits;

  localparam logic [ValueBits-1:0] ThresholdRst = ValueBits'(1966);
  localparam logic [ValueBits-1:0] SmoothingRst = ValueBits'(0);
  localparam logic [ValueBits-1:0] AbsentRst    = ValueBits'(1311);

  localparam logic [ValueBits-1:0] HalfScale = ValueBits'(1) << (ValueBits - 1);
  localparam logic [AccW-1:0]      RoundHalf = AccW'(1) << (ValueBits - 1);

  // saturation patterns of the signed Q5.12 result
  localparam logic [NormW-1:0] NormPosMax = {1'b0, {(NormW-1){1'b1}}};
  localparam logic [NormW-1:0] NormNegMax = {1'b1, {(NormW-1){1'b0}}};

  typedef enum logic [OpW-1:0] {
    OP_WEIGHT = 2'd0,
    OP_X      = 2'd1,
    OP_Y      = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SMOOTHING = 2'd1,
    REG_ABSENT    = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  // write request into the per-board store
  typedef struct packed {
    logic                 wr_weight;
    logic                 wr_x;
    logic                 wr_y;
    logic [BoardW-1:0]    board;
    logic [ValueBits-1:0] value;
    logic [ValueBits-1:0] peak;
  } store_wr_t;

  // per-board state read back for the current board
  typedef struct packed {
    logic [ValueBits-1:0] peak;
    logic [ValueBits-1:0] x_pos;
    logic [ValueBits-1:0] y_pos;
  } store_rd_t;

  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [ValueBits-1:0] mag;
    logic [ValueBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [NormW-1:0] norm;
  } div_res_t;

endpackage

`default_nettype wire

// File: hdl/balance_board_sample_conditioner.sv
// ----------------------------------------------------------------------------
// balance_board_sample_conditioner
// Per-board weight/peak tracking, position smoothing and normalization.
// ----------------------------------------------------------------------------
// One word is processed at a time; in_stall_o is high from acceptance until
// the result has been loaded into the output register. A weight word, an
// ignored position or an unknown kind is evaluated, then loaded into the
// output register. An applied position is evaluated, makes two passes
// through the shared 16x16 multiplier for the running average when
// smoothing is on, then goes through write-back and divider start, the
// one-bit-per-cycle divider that forms (position - 0.5) / peak, the
// capture of the signed and saturated quotient, then the output load. A
// zero peak or a quotient too large for 18 bits skips the divider
// iterations. The next word can be accepted in the cycle after the output
// load. The output register lets a new word be accepted while the previous
// result is still stalled at the output.
`default_nettype none
`include "balance_board_sample_conditioner_macros.svh"

module balance_board_sample_conditioner (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration
  input  wire                                   cfg_we_i,
  input  wire  [bbsc_pkg::CfgIdxW-1:0]          cfg_addr_i,
  input  wire  [bbsc_pkg::ValueBits-1:0]        cfg_wdata_i,
  // sample input
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [bbsc_pkg::BoardW-1:0]           board_i,
  input  wire  [bbsc_pkg::OpW-1:0]              op_i,
  input  wire  [bbsc_pkg::ValueBits-1:0]        sample_i,
  // result output
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [bbsc_pkg::BoardW-1:0]           board_echo_o,
  output logic [bbsc_pkg::OpW-1:0]              kind_echo_o,
  output logic                                  applied_o,
  output logic [bbsc_pkg::ValueBits-1:0]        stored_value_o,
  output logic [bbsc_pkg::ValueBits-1:0]        peak_weight_o,
  output logic signed [bbsc_pkg::NormW-1:0]     normalized_o,
  output logic                                  saturated_o
);
  import bbsc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_WB   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ValueBits-1:0] threshold_q, smoothing_q, absent_q;

  logic [BoardW-1:0]    board_q;
  logic [OpW-1:0]       op_q;
  logic [ValueBits-1:0] sample_q;
  logic [ValueBits-1:0] old_pos_q, old_pos_d;
  logic [AccW-1:0]      acc_q, acc_d;

  logic                 res_applied_q, res_applied_d;
  logic [ValueBits-1:0] res_stored_q, res_stored_d;
  logic [ValueBits-1:0] res_peak_q, res_peak_d;
  logic [NormW-1:0]     res_norm_q, res_norm_d;
  logic                 res_sat_q, res_sat_d;

  logic                 out_valid_q;
  logic                 out_load;

  store_wr_t            wr;
  store_rd_t            rd;
  div_req_t             div_req;
  div_res_t             div_res;

  logic                 board_ok;
  logic [ValueBits-1:0] mul_a, mul_b;
  logic [AccW-1:0]      prod;
  logic [ValueBits-1:0] new_pos;

  bbsc_board_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_board_i (board_q),
    .wr_i       (wr),
    .rd_o       (rd)
  );

  bbsc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      smoothing_q <= SmoothingRst;
      absent_q    <= AbsentRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_THRESHOLD: threshold_q <= cfg_wdata_i;
        REG_SMOOTHING: smoothing_q <= cfg_wdata_i;
        REG_ABSENT:    absent_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign board_ok   = (int'(board_q) < BoardCount);

  // shared multiplier: (1 - s) * sample first, then s * old position
  assign mul_a   = (state_q == S_MUL1) ? (ValueBits'(0) - smoothing_q) : smoothing_q;
  assign mul_b   = (state_q == S_MUL1) ? sample_q : old_pos_q;
  assign prod    = {{ValueBits{1'b0}}, mul_a} * {{ValueBits{1'b0}}, mul_b};
  assign new_pos = (smoothing_q == '0) ? sample_q : acc_q[AccW-1:ValueBits];

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    old_pos_d     = old_pos_q;
    acc_d         = acc_q;
    res_applied_d = res_applied_q;
    res_stored_d  = res_stored_q;
    res_peak_d    = res_peak_q;
    res_norm_d    = res_norm_q;
    res_sat_d     = res_sat_q;
    wr            = '0;
    wr.board      = board_q;
    div_req       = '0;
    div_req.divisor = res_peak_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_applied_d = 1'b0;
        res_stored_d  = '0;
        res_peak_d    = '0;
        res_norm_d    = '0;
        res_sat_d     = 1'b0;
        state_d       = S_OUT;
        if (board_ok) begin
          res_peak_d = rd.peak;
          case (op_q)
            OP_WEIGHT: begin
              res_applied_d = 1'b1;
              wr.wr_weight  = 1'b1;
              if (sample_q < threshold_q) begin
                wr.value = absent_q;
                wr.peak  = threshold_q;
              end else begin
                wr.value = sample_q;
                wr.peak  = (sample_q > rd.peak) ? sample_q : rd.peak;
              end
              res_stored_d = wr.value;
              res_peak_d   = wr.peak;
            end
            OP_X, OP_Y: begin
              old_pos_d = (op_q == OP_X) ? rd.x_pos : rd.y_pos;
              if (sample_q < threshold_q) begin
                res_stored_d = old_pos_d;
              end else begin
                res_applied_d = 1'b1;
                state_d       = (smoothing_q == '0) ? S_WB : S_MUL1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        acc_d   = prod + RoundHalf;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = acc_q + prod;
        state_d = S_WB;
      end
      S_WB: begin
        wr.wr_x       = (op_q == OP_X);
        wr.wr_y       = (op_q == OP_Y);
        wr.value      = new_pos;
        res_stored_d  = new_pos;
        div_req.start = 1'b1;
        div_req.neg   = (new_pos < HalfScale);
        div_req.mag   = div_req.neg ? (HalfScale - new_pos) : (new_pos - HalfScale);
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          res_norm_d = div_res.norm;
          res_sat_d  = div_res.sat;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      board_q  <= board_i;
      op_q     <= op_i;
      sample_q <= sample_i;
    end
    old_pos_q     <= old_pos_d;
    acc_q         <= acc_d;
    res_applied_q <= res_applied_d;
    res_stored_q  <= res_stored_d;
    res_peak_q    <= res_peak_d;
    res_norm_q    <= res_norm_d;
    res_sat_q     <= res_sat_d;
    if (out_load) begin
      board_echo_o   <= board_q;
      kind_echo_o    <= op_q;
      applied_o      <= res_applied_q;
      stored_value_o <= res_stored_q;
      peak_weight_o  <= res_peak_q;
      normalized_o   <= res_norm_q;
      saturated_o    <= res_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `BBSC_ASSERT_NXT(a_accept_to_eval, clk_i, rst_ni, in_valid_i && !in_stall_o,
                   state_q == S_EVAL, "accepted word did not enter evaluation")
  `BBSC_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_res.done,
                   state_q == S_DIV, "divider finished outside the divide state")
  `BBSC_ASSERT_IMP(a_weight_no_norm, clk_i, rst_ni,
                   out_valid_o && kind_echo_o == OP_WEIGHT,
                   !saturated_o && normalized_o == '0, "weight result carries a quotient")
  `BBSC_ASSERT_IMP(a_ignored_no_sat, clk_i, rst_ni, out_valid_o && !applied_o,
                   !saturated_o, "ignored word flagged as saturated")

endmodule

`default_nettype wire

// File: hdl/bbsc_board_store.sv
// ----------------------------------------------------------------------------
// bbsc_board_store
// Per-board weight, peak and position registers with one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsc_board_store (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  [bbsc_pkg::BoardW-1:0] rd_board_i,
  input  bbsc_pkg::store_wr_t        wr_i,
  output bbsc_pkg::store_rd_t        rd_o
);
  import bbsc_pkg::*;

  logic [ValueBits-1:0] weight_q [BoardCount];
  logic [ValueBits-1:0] peak_q   [BoardCount];
  logic [ValueBits-1:0] x_q      [BoardCount];
  logic [ValueBits-1:0] y_q      [BoardCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BoardCount; i++) begin
        weight_q[i] <= '0;
        peak_q[i]   <= '0;
        x_q[i]      <= '0;
        y_q[i]      <= '0;
      end
    end else begin
      if (wr_i.wr_weight) begin
        weight_q[wr_i.board] <= wr_i.value;
        peak_q[wr_i.board]   <= wr_i.peak;
      end
      if (wr_i.wr_x) begin
        x_q[wr_i.board] <= wr_i.value;
      end
      if (wr_i.wr_y) begin
        y_q[wr_i.board] <= wr_i.value;
      end
    end
  end

  assign rd_o.peak  = peak_q[rd_board_i];
  assign rd_o.x_pos = x_q[rd_board_i];
  assign rd_o.y_pos = y_q[rd_board_i];

endmodule

`default_nettype wire

// File: hdl/bbsc_divider.sv
// ----------------------------------------------------------------------------
// bbsc_divider
// Restoring divider, one quotient bit per cycle, for (mag << 12) / peak with
// sign and saturation to signed Q5.12.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsc_divider (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bbsc_pkg::div_req_t req_i,
  output bbsc_pkg::div_res_t res_o
);
  import bbsc_pkg::*;

  localparam int StepW = $clog2(QuotBits);
  localparam int DvdW  = ValueBits + FracShift;

  logic                 busy_q;
  logic                 fin_q;
  logic [StepW-1:0]     step_q;
  logic [ValueBits-1:0] rem_q;
  logic [QuotBits-1:0]  dvd_q;
  logic [ValueBits-1:0] divisor_q;
  logic                 neg_q;
  logic                 zero_q;
  logic                 ovf_q;
  logic                 mag_zero_q;

  logic [DvdW-1:0]        dividend;
  logic                   ovf;
  logic [ValueBits+1:0]   trial;
  logic                   fits;

  assign dividend = {req_i.mag, FracShift'(0)};
  // quotient needs more than QuotBits bits
  assign ovf = ({(QuotBits - FracShift)'(0), req_i.mag} >=
                {req_i.divisor, (QuotBits - FracShift)'(0)});

  assign trial = {1'b0, rem_q, dvd_q[QuotBits-1]} - {2'b00, divisor_q};
  assign fits  = !trial[ValueBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.divisor == '0 || ovf) begin
          fin_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          step_q <= StepW'(QuotBits - 1);
        end
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q      <= ValueBits'(dividend >> QuotBits);
      dvd_q      <= dividend[QuotBits-1:0];
      divisor_q  <= req_i.divisor;
      neg_q      <= req_i.neg;
      zero_q     <= (req_i.divisor == '0);
      ovf_q      <= ovf;
      mag_zero_q <= (req_i.mag == '0);
    end else if (busy_q) begin
      rem_q <= fits ? trial[ValueBits-1:0] : {rem_q[ValueBits-2:0], dvd_q[QuotBits-1]};
      dvd_q <= {dvd_q[QuotBits-2:0], fits};
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    res_o.done = fin_q;
    res_o.sat  = 1'b0;
    res_o.norm = '0;
    if (zero_q) begin
      res_o.sat  = 1'b1;
      res_o.norm = mag_zero_q ? '0 : (neg_q ? NormNegMax : NormPosMax);
    end else if (ovf_q) begin
      res_o.sat  = 1'b1;
      res_o.norm = neg_q ? NormNegMax : NormPosMax;
    end else if (neg_q) begin
      // magnitude of exactly 2^17 is still representable
      if (dvd_q[QuotBits-1] && (|dvd_q[QuotBits-2:0])) begin
        res_o.sat  = 1'b1;
        res_o.norm = NormNegMax;
      end else begin
        res_o.norm = NormW'(0) - dvd_q;
      end
    end else begin
      if (dvd_q[QuotBits-1]) begin
        res_o.sat  = 1'b1;
        res_o.norm = NormPosMax;
      end else begin
        res_o.norm = dvd_q;
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Sample conditioner testbench
// Drives board samples through the valid/stall input, predicts every result
// word from a local copy of the per-board state and compares each field of
// the output words in order. Runs a directed opening, then random samples
// under several register settings with random idling, a stretch without
// idling and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbsc_pkg::*;

  localparam int StuckLimit   = 5000;
  localparam int SettleCycles = 30;
  localparam int HoldCycles   = 400;

  typedef struct packed {
    logic [BoardW-1:0]    board;
    logic [OpW-1:0]       kind;
    logic                 applied;
    logic [ValueBits-1:0] stored;
    logic [ValueBits-1:0] peak;
    logic [NormW-1:0]     norm;
    logic                 sat;
  } sample_result_t;

  // Tracks per-board weight, peak and positions and queues the result word
  // each accepted sample should produce.
  class sample_scoreboard;
    bit [ValueBits-1:0] threshold;
    bit [ValueBits-1:0] smoothing;
    bit [ValueBits-1:0] absent;
    bit [ValueBits-1:0] weight_by_board[BoardCount];
    bit [ValueBits-1:0] peak_by_board[BoardCount];
    bit [ValueBits-1:0] x_by_board[BoardCount];
    bit [ValueBits-1:0] y_by_board[BoardCount];
    sample_result_t     due_results[$];
    int                 mismatches;

    function new();
      threshold  = ThresholdRst;
      smoothing  = SmoothingRst;
      absent     = AbsentRst;
      mismatches = 0;
    endfunction

    function void set_register(reg_idx_e idx, bit [ValueBits-1:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value;
        REG_SMOOTHING: smoothing = value;
        REG_ABSENT:    absent = value;
        default: ;
      endcase
    endfunction

    function bit [ValueBits-1:0] smooth_position(bit [ValueBits-1:0] old_pos,
                                                  bit [ValueBits-1:0] fresh);
      longint unsigned acc;
      if (smoothing == 0) return fresh;
      acc = ((64'd1 << ValueBits) - 64'(smoothing)) * 64'(fresh)
          + 64'(smoothing) * 64'(old_pos) + (64'd1 << (ValueBits - 1));
      return ValueBits'(acc >> ValueBits);
    endfunction

    // returns {saturated, normalized}
    function bit [NormW:0] offset_over_peak(bit [ValueBits-1:0] pos,
                                            bit [ValueBits-1:0] peak);
      longint unsigned mag;
      longint unsigned quot;
      bit              neg;
      bit              sat;
      bit [NormW-1:0]  norm;
      neg = pos < HalfScale;
      mag = neg ? 64'(HalfScale - pos) : 64'(pos - HalfScale);
      sat = 1'b0;
      if (peak == 0) begin
        sat  = 1'b1;
        norm = (mag == 0) ? '0 : (neg ? NormNegMax : NormPosMax);
      end else begin
        quot = (mag << FracShift) / 64'(peak);
        if (neg) begin
          if (quot > 64'(NormNegMax)) begin
            quot = 64'(NormNegMax);
            sat  = 1'b1;
          end
          norm = NormW'(64'd0 - quot);
        end else begin
          if (quot > 64'(NormPosMax)) begin
            quot = 64'(NormPosMax);
            sat  = 1'b1;
          end
          norm = NormW'(quot);
        end
      end
      return {sat, norm};
    endfunction

    function void note_sample(bit [BoardW-1:0] board, bit [OpW-1:0] op,
                              bit [ValueBits-1:0] sample);
      sample_result_t     want;
      op_e                kind;
      bit [ValueBits-1:0] pos;
      kind         = op_e'(op);
      want         = '0;
      want.board   = board;
      want.kind    = op;
      want.peak    = peak_by_board[board];
      case (kind)
        OP_WEIGHT: begin
          want.applied = 1'b1;
          if (sample < threshold) begin
            weight_by_board[board] = absent;
            peak_by_board[board]   = threshold;
          end else begin
            weight_by_board[board] = sample;
            if (sample > peak_by_board[board]) peak_by_board[board] = sample;
          end
          want.stored = weight_by_board[board];
          want.peak   = peak_by_board[board];
        end
        OP_X, OP_Y: begin
          pos = (kind == OP_X) ? x_by_board[board] : y_by_board[board];
          if (sample >= threshold) begin
            pos                      = smooth_position(pos, sample);
            want.applied             = 1'b1;
            {want.sat, want.norm}    = offset_over_peak(pos, peak_by_board[board]);
            if (kind == OP_X) x_by_board[board] = pos;
            else y_by_board[board] = pos;
          end
          want.stored = pos;
        end
        default: ;  // unknown kind leaves state alone, stored value reads zero
      endcase
      due_results.push_back(want);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(sample_result_t got);
      sample_result_t want;
      if (due_results.size() == 0) begin
        $error("result word for board %0d with nothing expected", got.board);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("board_echo", want.board, got.board);
      compare("kind_echo", want.kind, got.kind);
      compare("applied", want.applied, got.applied);
      compare("stored_value", want.stored, got.stored);
      compare("peak_weight", want.peak, got.peak);
      compare("normalized", want.norm, got.norm);
      compare("saturated", want.sat, got.sat);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CfgIdxW-1:0]            cfg_addr_i;
  logic [ValueBits-1:0]          cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [BoardW-1:0]             board_i;
  logic [OpW-1:0]                op_i;
  logic [ValueBits-1:0]          sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [BoardW-1:0]             board_echo_o;
  logic [OpW-1:0]                kind_echo_o;
  logic                          applied_o;
  logic [ValueBits-1:0]          stored_value_o;
  logic [ValueBits-1:0]          peak_weight_o;
  logic signed [NormW-1:0]       normalized_o;
  logic                          saturated_o;

  sample_scoreboard sb;
  int               in_idle_pct  = 35;
  int               out_idle_pct = 35;
  bit               hold_request = 1'b0;
  int               stuck_cycles = 0;

  balance_board_sample_conditioner u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .board_i        (board_i),
    .op_i           (op_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .board_echo_o   (board_echo_o),
    .kind_echo_o    (kind_echo_o),
    .applied_o      (applied_o),
    .stored_value_o (stored_value_o),
    .peak_weight_o  (peak_weight_o),
    .normalized_o   (normalized_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both handshakes are sampled here, before the block's registers move
  always @(posedge clk_i) begin : monitor
    sample_result_t seen;
    bit             took_in;
    bit             took_out;
    if (rst_ni) begin
      took_in  = in_valid_i && !in_stall_o;
      took_out = out_valid_o && !out_stall_i;
      if (took_in) sb.note_sample(board_i, op_i, sample_i);
      if (took_out) begin
        seen.board   = board_echo_o;
        seen.kind    = kind_echo_o;
        seen.applied = applied_o;
        seen.stored  = stored_value_o;
        seen.peak    = peak_weight_o;
        seen.norm    = normalized_o;
        seen.sat     = saturated_o;
        sb.check_result(seen);
      end
      stuck_cycles <= (took_in || took_out) ? 0 : stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_stall_i = ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  task automatic send_word(bit [BoardW-1:0] b, bit [OpW-1:0] o, bit [ValueBits-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    board_i    = b;
    op_i       = o;
    sample_i   = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drain every expected word, then give the pipeline time to settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_registers(bit [ValueBits-1:0] thr, bit [ValueBits-1:0] smooth,
                                   bit [ValueBits-1:0] absent_val);
    reg_idx_e           idx[3];
    bit [ValueBits-1:0] val[3];
    idx = '{REG_THRESHOLD, REG_SMOOTHING, REG_ABSENT};
    val = '{thr, smooth, absent_val};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_addr_i  = idx[i];
      cfg_wdata_i = val[i];
      sb.set_register(idx[i], val[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic bit [ValueBits-1:0] random_sample(bit [OpW-1:0] op);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return sb.threshold;
      3: return sb.threshold - 1'b1;
      4: begin
        // light weights drive the quotient into saturation
        if (op == OP_WEIGHT) return ValueBits'($urandom_range(1200));
        return HalfScale + ValueBits'($urandom_range(8)) - ValueBits'(4);
      end
      default: return ValueBits'($urandom());
    endcase
  endfunction

  function automatic bit [OpW-1:0] random_op();
    int pick;
    pick = $urandom_range(19);
    if (pick < 6) return OP_WEIGHT;
    if (pick < 12) return OP_X;
    if (pick < 18) return OP_Y;
    return OP_NONE;
  endfunction

  initial begin : stimulus
    bit [ValueBits-1:0] phase_thr[6];
    bit [ValueBits-1:0] phase_smooth[6];
    bit [ValueBits-1:0] phase_absent[6];
    int                 phase_words[6];
    bit [OpW-1:0]       op;

    phase_thr    = '{16'h0000, 16'hFFFF, 16'd500,  16'h0000, 16'd1966, 16'd1024};
    phase_smooth = '{16'h8000, 16'hFFFF, 16'd1,    16'h0000, 16'hC000, 16'h0000};
    phase_absent = '{16'h0000, 16'hFFFF, 16'h5555, 16'h0000, 16'd1311, 16'hAAAA};
    phase_words  = '{160, 80, 170, 170, 170, 180};

    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_THRESHOLD;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    board_i     = '0;
    op_i        = OP_WEIGHT;
    sample_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero peak, threshold edges, unknown kind
    send_word(3'd0, OP_X, 16'hFFFF);
    send_word(3'd1, OP_Y, HalfScale);
    send_word(3'd1, OP_Y, 16'd2000);
    send_word(3'd0, OP_Y, 16'd0);
    send_word(3'd0, OP_WEIGHT, 16'd1965);
    send_word(3'd0, OP_X, 16'd1966);
    send_word(3'd2, OP_WEIGHT, 16'hFFFF);
    send_word(3'd2, OP_X, 16'hFFFF);
    send_word(3'd2, OP_X, 16'd0);
    send_word(3'd2, OP_WEIGHT, 16'd30000);
    send_word(3'd2, OP_Y, 16'hC000);
    send_word(3'd7, OP_NONE, 16'hFFFF);
    send_word(3'd5, OP_NONE, 16'h0000);
    send_word(3'd6, OP_WEIGHT, 16'd1966);
    send_word(3'd6, OP_Y, 16'h8001);

    // zero threshold: peaks around 1024 sit right at the saturation boundary
    wait_idle();
    program_registers(16'h0000, SmoothingRst, AbsentRst);
    send_word(3'd4, OP_WEIGHT, 16'd1024);
    send_word(3'd4, OP_Y, 16'd0);
    send_word(3'd3, OP_WEIGHT, 16'd1023);
    send_word(3'd3, OP_Y, 16'd0);
    send_word(3'd3, OP_X, 16'hFFFF);
    send_word(3'd3, OP_WEIGHT, 16'd0);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 3) begin
        phase_thr[p]    = ValueBits'($urandom_range(4000));
        phase_smooth[p] = ValueBits'($urandom());
        phase_absent[p] = ValueBits'($urandom());
      end
      program_registers(phase_thr[p], phase_smooth[p], phase_absent[p]);
      for (int n = 0; n < phase_words[p]; n++) begin
        if (p == 0 && n == 40) begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
        if (p == 0 && n == 120) begin
          in_idle_pct  = 35;
          out_idle_pct = 35;
        end
        // sender keeps offering words while the output is held off
        if (p == 2 && n == 30) hold_request = 1'b1;
        op = random_op();
        send_word(BoardW'($urandom_range(BoardCount - 1)), op, random_sample(op));
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
